>>> rtl/assert_macros.svh
// Assertion macros used by the checker file of the joint effort clamp.
// Holds macro definitions only; included by jslec_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define JSLEC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jslec check failed");

// Next-cycle implication, disabled while reset is held.
`define JSLEC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jslec check failed");

// Next-cycle implication that also holds across reset.
`define JSLEC_ASSERT_RST(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("jslec reset check failed");

`endif

>>> rtl/jslec_pkg.sv
// Package of the joint effort clamp: widths, register indexes and shared types.
// No dependencies; used by jslec_gc_pair and the top level.
package jslec_pkg;

    localparam int DATA_W        = 32;
    localparam int LIMIT_W       = 31;
    localparam int CFG_IDX_W     = 3;
    localparam int FRAC_BITS_DEF = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LIMITS_ENABLED   = 3'd0,
        REG_POSITION_BOUNDED = 3'd1,
        REG_VELOCITY_LIMIT   = 3'd2,
        REG_EFFORT_LIMIT     = 3'd3,
        REG_POSITION_GAIN    = 3'd4,
        REG_VELOCITY_GAIN    = 3'd5,
        REG_SOFT_UPPER       = 3'd6,
        REG_SOFT_LOWER       = 3'd7
    } t_cfg_reg;

    // Static settings of one gain-and-saturate unit.
    typedef struct packed {
        logic [DATA_W-1:0]  gain;
        logic [LIMIT_W-1:0] limit;
    } t_gc_cfg;

endpackage

>>> rtl/jslec_gc_pair.sv
// Two-lane gain-and-saturate pipeline: bound = -sat(gain * (a - b) >> F).
// Three register stages (difference, product, saturation); uses jslec_pkg.
module jslec_gc_pair #(
    parameter int FRAC_BITS = jslec_pkg::FRAC_BITS_DEF,
    parameter int SIDE_W    = 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  jslec_pkg::t_gc_cfg                i_cfg,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [jslec_pkg::DATA_W-1:0] i_a,
    input  logic signed [jslec_pkg::DATA_W-1:0] i_b_hi,
    input  logic signed [jslec_pkg::DATA_W-1:0] i_b_lo,
    input  logic [SIDE_W-1:0]                 i_side,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [jslec_pkg::DATA_W-1:0] o_bound_hi,
    output logic signed [jslec_pkg::DATA_W-1:0] o_bound_lo,
    output logic [SIDE_W-1:0]                 o_side
);
    localparam int DW = jslec_pkg::DATA_W;
    localparam int MW = DW + 1;
    localparam int PW = DW + MW;

    logic r_v1, r_v2, r_v3;
    logic rdy1, rdy2, rdy3;

    logic [MW-1:0]   r_mag_hi, r_mag_lo;
    logic            r_neg1_hi, r_neg1_lo;
    logic [SIDE_W-1:0] r_side1, r_side2, r_side3;
    logic [PW-1:0]   r_prod_hi, r_prod_lo;
    logic            r_neg2_hi, r_neg2_lo;
    logic signed [DW-1:0] r_bnd_hi, r_bnd_lo;

    logic signed [MW-1:0] diff_hi, diff_lo;
    logic [MW-1:0]   n_mag_hi, n_mag_lo;
    logic signed [DW-1:0] n_bnd_hi, n_bnd_lo;

    function automatic logic signed [DW-1:0] sat_bound(
        input logic [PW-1:0] prod, input logic neg, input logic [jslec_pkg::LIMIT_W-1:0] lim);
        logic [PW-1:0] shifted;
        logic [jslec_pkg::LIMIT_W-1:0] m;
        shifted = prod >> FRAC_BITS;
        if (shifted > PW'(lim)) begin
            m = lim;
        end else begin
            m = shifted[jslec_pkg::LIMIT_W-1:0];
        end
        // A negative difference gives a positive bound and vice versa.
        return neg ? $signed(DW'(m)) : -$signed(DW'(m));
    endfunction

    assign rdy3    = !r_v3 || i_ready;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;

    always_comb begin
        diff_hi  = MW'(i_a) - MW'(i_b_hi);
        diff_lo  = MW'(i_a) - MW'(i_b_lo);
        n_mag_hi = diff_hi[MW-1] ? MW'(-diff_hi) : MW'(diff_hi);
        n_mag_lo = diff_lo[MW-1] ? MW'(-diff_lo) : MW'(diff_lo);
        n_bnd_hi = sat_bound(r_prod_hi, r_neg2_hi, i_cfg.limit);
        n_bnd_lo = sat_bound(r_prod_lo, r_neg2_lo, i_cfg.limit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_mag_hi  <= n_mag_hi;
            r_mag_lo  <= n_mag_lo;
            r_neg1_hi <= diff_hi[MW-1];
            r_neg1_lo <= diff_lo[MW-1];
            r_side1   <= i_side;
        end
        if (rdy2 && r_v1) begin
            r_prod_hi <= PW'(i_cfg.gain) * PW'(r_mag_hi);
            r_prod_lo <= PW'(i_cfg.gain) * PW'(r_mag_lo);
            r_neg2_hi <= r_neg1_hi;
            r_neg2_lo <= r_neg1_lo;
            r_side2   <= r_side1;
        end
        if (rdy3 && r_v2) begin
            r_bnd_hi <= n_bnd_hi;
            r_bnd_lo <= n_bnd_lo;
            r_side3  <= r_side2;
        end
    end

    assign o_valid    = r_v3;
    assign o_bound_hi = r_bnd_hi;
    assign o_bound_lo = r_bnd_lo;
    assign o_side     = r_side3;

endmodule

>>> rtl/joint_soft_limit_effort_clamp.sv
// Top level of the joint soft-limit effort clamp: register file, two gain
// pipelines and the final clamp stage. Depends on jslec_pkg and jslec_gc_pair.
//
// One joint sample enters per word on the slave stream and one result word
// leaves on the master stream, held there until the output accepts it.
// A new sample may be taken in every cycle, so the sustained rate
// is one word per clock; the latency is set by the two chained 32 by 33 bit
// gain multipliers, each of which sits in a three-stage unit of its own
// (difference, product, saturation), followed by one register for the final
// clamp of the commanded effort. The first unit turns the distance to the
// soft position limits into a velocity window; the second turns the velocity
// error against that window into an effort window. Every stage holds its own
// valid bit and stalls only when the stage after it is full, so gaps and
// back-pressure lose or repeat nothing. Configuration registers are written
// through a separate channel that is always ready; they should be changed only
// while no sample is in flight. All arithmetic is signed fixed point with
// FRAC_BITS fraction bits, and gain products saturate at the relevant limit.
module joint_soft_limit_effort_clamp #(
    parameter int FRAC_BITS = jslec_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [jslec_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,  // [31:0] position, [63:32] velocity,
                                       // [95:64] commanded_effort
    input  logic        s_axis_tuser,  // [0] calibrated
    // Output stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata   // [31:0] limited_effort, [63:32] lower effort
                                       // bound, [95:64] upper effort bound
);
    localparam int DW     = jslec_pkg::DATA_W;
    localparam int LW     = jslec_pkg::LIMIT_W;
    localparam int SIDE1_W = 2 * DW + 1;

    // Configuration registers.
    logic              r_limits_enabled;
    logic              r_position_bounded;
    logic [LW-1:0]     r_velocity_limit;
    logic [LW-1:0]     r_effort_limit;
    logic [DW-1:0]     r_position_gain;
    logic [DW-1:0]     r_velocity_gain;
    logic signed [DW-1:0] r_soft_upper;
    logic signed [DW-1:0] r_soft_lower;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limits_enabled   <= 1'b0;
            r_position_bounded <= 1'b0;
            r_velocity_limit   <= '0;
            r_effort_limit     <= '0;
            r_position_gain    <= '0;
            r_velocity_gain    <= '0;
            r_soft_upper       <= '0;
            r_soft_lower       <= '0;
        end else if (i_cfg_valid) begin
            case (jslec_pkg::t_cfg_reg'(i_cfg_index))
                jslec_pkg::REG_LIMITS_ENABLED:   r_limits_enabled   <= i_cfg_data[0];
                jslec_pkg::REG_POSITION_BOUNDED: r_position_bounded <= i_cfg_data[0];
                jslec_pkg::REG_VELOCITY_LIMIT:   r_velocity_limit   <= i_cfg_data[LW-1:0];
                jslec_pkg::REG_EFFORT_LIMIT:     r_effort_limit     <= i_cfg_data[LW-1:0];
                jslec_pkg::REG_POSITION_GAIN:    r_position_gain    <= i_cfg_data;
                jslec_pkg::REG_VELOCITY_GAIN:    r_velocity_gain    <= i_cfg_data;
                jslec_pkg::REG_SOFT_UPPER:       r_soft_upper       <= $signed(i_cfg_data);
                jslec_pkg::REG_SOFT_LOWER:       r_soft_lower       <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Unpack the input word.
    logic signed [DW-1:0] in_pos, in_vel, in_cmd;
    logic                 in_use_pos;

    assign in_pos     = $signed(s_axis_tdata[31:0]);
    assign in_vel     = $signed(s_axis_tdata[63:32]);
    assign in_cmd     = $signed(s_axis_tdata[95:64]);
    // Soft position bounds apply only to a calibrated joint of a bounded type.
    assign in_use_pos = s_axis_tuser & r_position_bounded;

    // Position to velocity window.
    jslec_pkg::t_gc_cfg   pos_cfg, vel_cfg;
    logic                 v_valid, v_ready;
    logic signed [DW-1:0] v_bnd_hi, v_bnd_lo;
    logic [SIDE1_W-1:0]   v_side;

    assign pos_cfg.gain  = r_position_gain;
    assign pos_cfg.limit = r_velocity_limit;

    jslec_gc_pair #(
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    (SIDE1_W)
    ) u_pos_gc (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (pos_cfg),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_a        (in_pos),
        .i_b_hi     (r_soft_upper),
        .i_b_lo     (r_soft_lower),
        .i_side     ({in_use_pos, in_cmd, in_vel}),
        .o_valid    (v_valid),
        .i_ready    (v_ready),
        .o_bound_hi (v_bnd_hi),
        .o_bound_lo (v_bnd_lo),
        .o_side     (v_side)
    );

    // Pick the velocity window: from the soft limits, or the plain symmetric limit.
    logic signed [DW-1:0] v_vel, v_cmd, vel_hi, vel_lo;
    logic                 v_use_pos;

    assign v_vel     = $signed(v_side[DW-1:0]);
    assign v_cmd     = $signed(v_side[2*DW-1:DW]);
    assign v_use_pos = v_side[2*DW];
    assign vel_hi    = v_use_pos ? v_bnd_hi : $signed(DW'(r_velocity_limit));
    assign vel_lo    = v_use_pos ? v_bnd_lo : -$signed(DW'(r_velocity_limit));

    // Velocity error to effort window.
    logic                 e_valid, e_ready;
    logic signed [DW-1:0] e_hi, e_lo;
    logic [DW-1:0]        e_cmd;

    assign vel_cfg.gain  = r_velocity_gain;
    assign vel_cfg.limit = r_effort_limit;

    jslec_gc_pair #(
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    (DW)
    ) u_vel_gc (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (vel_cfg),
        .i_valid    (v_valid),
        .o_ready    (v_ready),
        .i_a        (v_vel),
        .i_b_hi     (vel_hi),
        .i_b_lo     (vel_lo),
        .i_side     (v_cmd),
        .o_valid    (e_valid),
        .i_ready    (e_ready),
        .o_bound_hi (e_hi),
        .o_bound_lo (e_lo),
        .o_side     (e_cmd)
    );

    // Final clamp and output register. With limits disabled the window spans
    // the whole range and the command passes through. An inverted window
    // yields the upper bound, as the upper clamp is applied last.
    logic                 r_out_valid;
    logic signed [DW-1:0] r_res, r_lo, r_hi;
    logic signed [DW-1:0] n_res, n_lo, n_hi, cmd_s, tmp;

    assign e_ready = !r_out_valid || m_axis_tready;

    always_comb begin
        cmd_s = $signed(e_cmd);
        if (r_limits_enabled) begin
            n_lo = e_lo;
            n_hi = e_hi;
        end else begin
            n_lo = $signed({1'b1, {(DW-1){1'b0}}});
            n_hi = $signed({1'b0, {(DW-1){1'b1}}});
        end
        tmp   = (cmd_s < n_lo) ? n_lo : cmd_s;
        n_res = (tmp > n_hi) ? n_hi : tmp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (e_ready) begin
            r_out_valid <= e_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (e_ready && e_valid) begin
            r_res <= n_res;
            r_lo  <= n_lo;
            r_hi  <= n_hi;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_hi, r_lo, r_res};

endmodule

>>> rtl/jslec_checker.sv
// Port-level checker of the joint effort clamp, bound to the top level.
// Depends on assert_macros.svh and on the top level's port names.
`include "assert_macros.svh"

module jslec_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [95:0] m_axis_tdata
);
    logic signed [31:0] res, lo, hi;

    assign res = $signed(m_axis_tdata[31:0]);
    assign lo  = $signed(m_axis_tdata[63:32]);
    assign hi  = $signed(m_axis_tdata[95:64]);

    // A held result word keeps its data.
    `JSLEC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))

    // The pipeline only refuses input while a result is waiting at the output.
    `JSLEC_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, !s_axis_tready, m_axis_tvalid)

    // A proper window contains the limited effort.
    `JSLEC_ASSERT_IMP(a_in_window, i_clk, i_rst_n, m_axis_tvalid && (lo <= hi), (res >= lo) && (res <= hi))

    // An inverted window gives its upper bound.
    `JSLEC_ASSERT_IMP(a_inverted, i_clk, i_rst_n, m_axis_tvalid && (lo > hi), res == hi)

    // Reset empties the pipeline.
    `JSLEC_ASSERT_RST(a_reset_empty, i_clk, !i_rst_n, !m_axis_tvalid)

endmodule

bind joint_soft_limit_effort_clamp jslec_checker u_jslec_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
